FILE: rtl/lci_pkg.sv
// ----------------------------------------------------------------------------
// Line / cylinder intersection: shared package
// Pipeline constants and elaboration helpers used by the top level and the
// split multiplier.
// ----------------------------------------------------------------------------
package lci_pkg;

   // Cycles from operands to product in the split multiplier.
   localparam int unsigned MUL_LATENCY = 3;

   // Half of a width, rounded up.
   function automatic int unsigned half_up(input int unsigned w);
      return (w + 1) >> 1;
   endfunction

endpackage

FILE: rtl/lci_mul.sv
// ----------------------------------------------------------------------------
// Line / cylinder intersection: split multiplier
// Unsigned multiplier cut into four half-width partial products, summed over
// two more register stages.
// ----------------------------------------------------------------------------
module lci_mul
   import lci_pkg::*;
#(
   parameter int unsigned AW = 36,
   parameter int unsigned BW = 36
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [AW-1:0]    a_i,
   input  logic [BW-1:0]    b_i,
   output logic [AW+BW-1:0] prod_o
);

   localparam int unsigned HA = half_up(AW);
   localparam int unsigned HB = half_up(BW);
   localparam int unsigned PW = AW + BW;

   logic [HA+HB-1:0]               ll_ff;
   logic [HA+(BW-HB)-1:0]          lh_ff;
   logic [(AW-HA)+HB-1:0]          hl_ff;
   logic [(AW-HA)+(BW-HB)-1:0]     hh_ff;
   logic [PW-1:0]                  mid_ff;
   logic [PW-1:0]                  base_ff;
   logic [PW-1:0]                  prod_ff;

   // Partial products, then the cross terms, then the final sum.
   always_ff @(posedge clock) begin
      if (adv) begin
         ll_ff   <= a_i[HA-1:0] * b_i[HB-1:0];
         lh_ff   <= a_i[HA-1:0] * b_i[BW-1:HB];
         hl_ff   <= a_i[AW-1:HA] * b_i[HB-1:0];
         hh_ff   <= a_i[AW-1:HA] * b_i[BW-1:HB];
         mid_ff  <= (PW'(lh_ff) << HB) + (PW'(hl_ff) << HA);
         base_ff <= {hh_ff, ll_ff};
         prod_ff <= base_ff + mid_ff;
      end
   end

   assign prod_o = prod_ff;

endmodule

FILE: rtl/lci_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Line / cylinder intersection: square root cell
// One step of the digit-by-digit integer square root: brings down two
// radicand bits and decides one root bit.
// ----------------------------------------------------------------------------
module lci_sqrt_cell #(
   parameter int unsigned SW = 52,
   parameter int unsigned TW = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              valid_i,
   input  logic [TW-1:0]     tag_i,
   input  logic [SW+1:0]     rem_i,
   input  logic [SW-1:0]     root_i,
   input  logic [2*SW-1:0]   rad_i,
   output logic              valid_o,
   output logic [TW-1:0]     tag_o,
   output logic [SW+1:0]     rem_o,
   output logic [SW-1:0]     root_o,
   output logic [2*SW-1:0]   rad_o
);

   logic              valid_ff;
   logic [TW-1:0]     tag_ff;
   logic [SW+1:0]     rem_ff;
   logic [SW-1:0]     root_ff;
   logic [2*SW-1:0]   rad_ff;
   logic [SW+1:0]     rem_sh;
   logic [SW+1:0]     trial;
   logic              take;
   logic [SW+1:0]     rem_in;

   // Trial subtraction of 4*root + 1 from the shifted remainder.
   always_comb begin
      rem_sh = {rem_i[SW-1:0], rad_i[2*SW-1 -: 2]};
      trial  = {root_i, 2'b01};
      take   = rem_sh >= trial;
      rem_in = take ? rem_sh - trial : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff  <= tag_i;
         rem_ff  <= rem_in;
         root_ff <= {root_i[SW-2:0], take};
         rad_ff  <= {rad_i[2*SW-3:0], 2'b00};
      end
   end

   assign valid_o = valid_ff;
   assign tag_o   = tag_ff;
   assign rem_o   = rem_ff;
   assign root_o  = root_ff;
   assign rad_o   = rad_ff;

endmodule

FILE: rtl/lci_div_cell.sv
// ----------------------------------------------------------------------------
// Line / cylinder intersection: divider cell
// One step of restoring division: shifts out one numerator bit and shifts in
// one quotient bit in the same register.
// ----------------------------------------------------------------------------
module lci_div_cell #(
   parameter int unsigned NW = 70,
   parameter int unsigned AW = 36,
   parameter int unsigned TW = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            valid_i,
   input  logic [TW-1:0]   tag_i,
   input  logic [AW-1:0]   rem_i,
   input  logic [NW-1:0]   nq_i,
   input  logic [AW-1:0]   den_i,
   output logic            valid_o,
   output logic [TW-1:0]   tag_o,
   output logic [AW-1:0]   rem_o,
   output logic [NW-1:0]   nq_o,
   output logic [AW-1:0]   den_o
);

   logic            valid_ff;
   logic [TW-1:0]   tag_ff;
   logic [AW-1:0]   rem_ff;
   logic [NW-1:0]   nq_ff;
   logic [AW-1:0]   den_ff;
   logic [AW:0]     rem_sh;
   logic [AW:0]     den_x;
   logic            take;
   logic [AW-1:0]   rem_in;

   // Compare the shifted remainder with the divisor and subtract on a hit.
   always_comb begin
      rem_sh = {rem_i, nq_i[NW-1]};
      den_x  = {1'b0, den_i};
      take   = rem_sh >= den_x;
      rem_in = take ? AW'(rem_sh - den_x) : rem_sh[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff <= tag_i;
         rem_ff <= rem_in;
         nq_ff  <= {nq_i[NW-2:0], take};
         den_ff <= den_i;
      end
   end

   assign valid_o = valid_ff;
   assign tag_o   = tag_ff;
   assign rem_o   = rem_ff;
   assign nq_o    = nq_ff;
   assign den_o   = den_ff;

endmodule

FILE: rtl/line_cylinder_intersect.sv
// Default widths give 52 square root cells and 70 divider cells.
// Throughput: one item per cycle, limited by nothing but the output handshake.
// Each chain retires one item per cycle unless the pipeline is stalled.
// Reset clears all valid bits, the skid entry and the radius register (to 0).
// ----------------------------------------------------------------------------
// Line / cylinder intersection: top level
// Intersects a track with a cylinder about the z axis in Q fixed point: a
// pipelined quadratic setup, a chain of square root cells, a chain of divider
// cells and a pipelined hit point stage.
// ----------------------------------------------------------------------------
module line_cylinder_intersect
   import lci_pkg::*;
#(
   parameter int unsigned COORD_WIDTH = 32,
   parameter int unsigned FRAC_BITS   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [COORD_WIDTH-2:0]          csr_wr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [COORD_WIDTH-1:0]   req_start_x,
   input  logic signed [COORD_WIDTH-1:0]   req_start_y,
   input  logic signed [COORD_WIDTH-1:0]   req_start_z,
   input  logic signed [FRAC_BITS+1:0]     req_dir_x,
   input  logic signed [FRAC_BITS+1:0]     req_dir_y,
   input  logic signed [FRAC_BITS+1:0]     req_dir_z,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [COORD_WIDTH-1:0]   rsp_path_param,
   output logic signed [COORD_WIDTH-1:0]   rsp_hit_x,
   output logic signed [COORD_WIDTH-1:0]   rsp_hit_y,
   output logic signed [COORD_WIDTH-1:0]   rsp_hit_z,
   output logic                            rsp_no_hit,
   output logic                            rsp_behind_start
);

   localparam int unsigned C    = COORD_WIDTH;
   localparam int unsigned F    = FRAC_BITS;
   localparam int unsigned DIRW = F + 2;
   localparam int unsigned RW   = C - 1;
   localparam int unsigned AW   = 2 * DIRW;
   localparam int unsigned BW   = C + DIRW + 1;
   localparam int unsigned PW   = 2 * C;
   localparam int unsigned R2W  = 2 * RW;
   localparam int unsigned UUW  = 2 * BW;
   localparam int unsigned ARW  = AW + R2W;
   localparam int unsigned APW  = AW + PW;
   localparam int unsigned POSW = ((UUW > ARW) ? UUW : ARW) + 1;
   localparam int unsigned DW0  = (POSW > APW) ? POSW : APW;
   localparam int unsigned SW   = half_up(DW0);
   localparam int unsigned DW   = 2 * SW;
   localparam int unsigned NSW  = ((SW + 1 > BW) ? SW + 1 : BW) + 1;
   localparam int unsigned NW   = NSW + F;
   localparam int unsigned XW   = DIRW + C;
   localparam int unsigned HW   = XW + 1;

   typedef struct packed {
      logic signed [C-1:0]    x0;
      logic signed [C-1:0]    y0;
      logic signed [C-1:0]    z0;
      logic signed [DIRW-1:0] dx;
      logic signed [DIRW-1:0] dy;
      logic signed [DIRW-1:0] dz;
   } trk_type;

   typedef struct packed {
      trk_type              trk;
      logic signed [BW-1:0] b;
      logic [AW-1:0]        a;
      logic                 nohit;
   } sq_tag_type;

   typedef struct packed {
      trk_type trk;
      logic    neg;
      logic    behind;
      logic    nohit;
   } dv_tag_type;

   typedef struct packed {
      logic signed [C-1:0] path;
      logic signed [C-1:0] hx;
      logic signed [C-1:0] hy;
      logic signed [C-1:0] hz;
      logic                no_hit;
      logic                behind;
   } res_type;

   localparam int unsigned SQTW = $bits(sq_tag_type);
   localparam int unsigned DVTW = $bits(dv_tag_type);

   // Saturate a widened coordinate to the signed coordinate range.
   function automatic logic signed [C-1:0] sat_c(input logic signed [HW-1:0] v);
      logic signed [C-1:0] r;
      if (v[HW-1:C-1] == {(HW-C+1){v[HW-1]}}) begin
         r = v[C-1:0];
      end else begin
         r = v[HW-1] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
      end
      return r;
   endfunction

   logic adv;
   logic skid_full_ff;

   assign adv       = !skid_full_ff;
   assign req_stall = skid_full_ff;

   // ------------------------------------------------------------------------
   // Radius register and its square.
   // ------------------------------------------------------------------------
   logic [RW-1:0]  radius_ff;
   logic [R2W-1:0] r2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
      end else if (csr_wr_en) begin
         radius_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      r2_ff <= radius_ff * radius_ff;
   end

   // ------------------------------------------------------------------------
   // Valid bits of the setup and finishing stages.
   // ------------------------------------------------------------------------
   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic vp1_ff, vp2_ff, vp3_ff, vt1_ff, vt2_ff, vh1_ff, vh2_ff;
   logic mv_ff [MUL_LATENCY];
   logic sq_v [SW+1];
   logic dv_v [NW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff  <= 1'b0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         vp1_ff <= 1'b0;
         vp2_ff <= 1'b0;
         vp3_ff <= 1'b0;
         vt1_ff <= 1'b0;
         vt2_ff <= 1'b0;
         vh1_ff <= 1'b0;
         vh2_ff <= 1'b0;
         for (int i = 0; i < MUL_LATENCY; i++) begin
            mv_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         v0_ff    <= req_valid;
         v1_ff    <= v0_ff;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         mv_ff[0] <= v3_ff;
         for (int i = 1; i < MUL_LATENCY; i++) begin
            mv_ff[i] <= mv_ff[i-1];
         end
         v4_ff  <= mv_ff[MUL_LATENCY-1];
         v5_ff  <= v4_ff;
         vp1_ff <= sq_v[SW];
         vp2_ff <= vp1_ff;
         vp3_ff <= vp2_ff;
         vt1_ff <= dv_v[NW];
         vt2_ff <= vt1_ff;
         vh1_ff <= vt2_ff;
         vh2_ff <= vh1_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Setup: products and sums of the quadratic coefficients.
   // ------------------------------------------------------------------------
   trk_type              trk0_ff, trk1_ff, trk2_ff;
   logic [C-1:0]         ux0_ff, uy0_ff;
   logic signed [AW-1:0] dxx1_ff, dyy1_ff;
   logic signed [C+DIRW-1:0] bx1_ff, by1_ff;
   logic [PW-1:0]        uxx1_ff, uyy1_ff;
   logic [AW-1:0]        a2_ff;
   logic signed [BW-1:0] b2_ff;
   logic [PW-1:0]        p2_ff;
   sq_tag_type           tag3_ff;
   logic [BW-1:0]        ub3_ff;
   logic [PW-1:0]        p3_ff;
   trk_type              trk_in;
   logic [C-1:0]         ux_in, uy_in;

   always_comb begin
      trk_in.x0 = req_start_x;
      trk_in.y0 = req_start_y;
      trk_in.z0 = req_start_z;
      trk_in.dx = req_dir_x;
      trk_in.dy = req_dir_y;
      trk_in.dz = req_dir_z;
      ux_in     = req_start_x[C-1] ? C'(-req_start_x) : C'(req_start_x);
      uy_in     = req_start_y[C-1] ? C'(-req_start_y) : C'(req_start_y);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         trk0_ff <= trk_in;
         ux0_ff  <= ux_in;
         uy0_ff  <= uy_in;

         trk1_ff <= trk0_ff;
         dxx1_ff <= $signed(trk0_ff.dx) * $signed(trk0_ff.dx);
         dyy1_ff <= $signed(trk0_ff.dy) * $signed(trk0_ff.dy);
         bx1_ff  <= $signed(trk0_ff.x0) * $signed(trk0_ff.dx);
         by1_ff  <= $signed(trk0_ff.y0) * $signed(trk0_ff.dy);
         uxx1_ff <= ux0_ff * ux0_ff;
         uyy1_ff <= uy0_ff * uy0_ff;

         trk2_ff <= trk1_ff;
         a2_ff   <= AW'(dxx1_ff + dyy1_ff);
         b2_ff   <= BW'(bx1_ff) + BW'(by1_ff);
         p2_ff   <= uxx1_ff + uyy1_ff;

         tag3_ff.trk   <= trk2_ff;
         tag3_ff.b     <= b2_ff;
         tag3_ff.a     <= a2_ff;
         tag3_ff.nohit <= (a2_ff == '0);
         ub3_ff        <= b2_ff[BW-1] ? BW'(-b2_ff) : BW'(b2_ff);
         p3_ff         <= p2_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Discriminant terms: B*B, A*R*R and A*(x0^2 + y0^2).
   // ------------------------------------------------------------------------
   logic [UUW-1:0] uu;
   logic [ARW-1:0] ar;
   logic [APW-1:0] ap;
   sq_tag_type     mtag_ff [MUL_LATENCY];

   lci_mul #(.AW(BW), .BW(BW)) u_mul_bb (
      .clock (clock), .adv (adv), .a_i (ub3_ff), .b_i (ub3_ff), .prod_o (uu)
   );

   lci_mul #(.AW(AW), .BW(R2W)) u_mul_ar (
      .clock (clock), .adv (adv), .a_i (tag3_ff.a), .b_i (r2_ff), .prod_o (ar)
   );

   lci_mul #(.AW(AW), .BW(PW)) u_mul_ap (
      .clock (clock), .adv (adv), .a_i (tag3_ff.a), .b_i (p3_ff), .prod_o (ap)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         mtag_ff[0] <= tag3_ff;
         for (int i = 1; i < MUL_LATENCY; i++) begin
            mtag_ff[i] <= mtag_ff[i-1];
         end
      end
   end

   // Sum of the positive terms, then the difference whose borrow flags a miss.
   sq_tag_type     tag4_ff, tag5_ff;
   logic [POSW-1:0] pos4_ff;
   logic [APW-1:0]  ap4_ff;
   logic [DW-1:0]   rad5_ff;
   logic [DW:0]     diff;

   assign diff = {1'b0, DW'(pos4_ff)} - {1'b0, DW'(ap4_ff)};

   always_ff @(posedge clock) begin
      if (adv) begin
         tag4_ff <= mtag_ff[MUL_LATENCY-1];
         pos4_ff <= POSW'(uu) + POSW'(ar);
         ap4_ff  <= ap;

         tag5_ff.trk   <= tag4_ff.trk;
         tag5_ff.b     <= tag4_ff.b;
         tag5_ff.a     <= tag4_ff.a;
         tag5_ff.nohit <= tag4_ff.nohit | diff[DW];
         rad5_ff       <= diff[DW-1:0];
      end
   end

   // ------------------------------------------------------------------------
   // Square root chain: one root bit per cell.
   // ------------------------------------------------------------------------
   logic [SW+1:0]   sq_rem  [SW+1];
   logic [SW-1:0]   sq_root [SW+1];
   logic [DW-1:0]   sq_rad  [SW+1];
   logic [SQTW-1:0] sq_tag  [SW+1];

   assign sq_v[0]    = v5_ff;
   assign sq_tag[0]  = tag5_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_rad[0]  = rad5_ff;

   for (genvar g = 0; g < SW; g++) begin : g_sqrt
      lci_sqrt_cell #(.SW(SW), .TW(SQTW)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .valid_i (sq_v[g]),
         .tag_i   (sq_tag[g]),
         .rem_i   (sq_rem[g]),
         .root_i  (sq_root[g]),
         .rad_i   (sq_rad[g]),
         .valid_o (sq_v[g+1]),
         .tag_o   (sq_tag[g+1]),
         .rem_o   (sq_rem[g+1]),
         .root_o  (sq_root[g+1]),
         .rad_o   (sq_rad[g+1])
      );
   end

   // ------------------------------------------------------------------------
   // Root choice: larger root, or the smaller one when the larger is negative.
   // ------------------------------------------------------------------------
   sq_tag_type            sq_end;
   logic signed [NSW-1:0] s_x, b_x;
   trk_type               trkp1_ff, trkp2_ff;
   logic [AW-1:0]         ap1_ff, ap2_ff;
   logic                  nhp1_ff, nhp2_ff, behind2_ff;
   logic signed [NSW-1:0] nsa1_ff, nsb1_ff, n2_ff;
   logic [NSW-1:0]        m_in;
   dv_tag_type            dtag3_ff;
   logic [AW-1:0]         den3_ff;
   logic [NW-1:0]         nq3_ff;

   always_comb begin
      sq_end = sq_tag[SW];
      s_x    = NSW'($signed({1'b0, sq_root[SW]}));
      b_x    = NSW'(sq_end.b);
      m_in   = n2_ff[NSW-1] ? NSW'(-n2_ff) : NSW'(n2_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         trkp1_ff <= sq_end.trk;
         ap1_ff   <= sq_end.a;
         nhp1_ff  <= sq_end.nohit;
         nsa1_ff  <= s_x - b_x;
         nsb1_ff  <= -b_x - s_x;

         trkp2_ff   <= trkp1_ff;
         ap2_ff     <= ap1_ff;
         nhp2_ff    <= nhp1_ff;
         behind2_ff <= nsa1_ff[NSW-1];
         n2_ff      <= nsa1_ff[NSW-1] ? nsb1_ff : nsa1_ff;

         dtag3_ff.trk    <= trkp2_ff;
         dtag3_ff.neg    <= n2_ff[NSW-1];
         dtag3_ff.behind <= behind2_ff;
         dtag3_ff.nohit  <= nhp2_ff;
         den3_ff         <= ap2_ff;
         nq3_ff          <= {m_in, {F{1'b0}}};
      end
   end

   // ------------------------------------------------------------------------
   // Divider chain: one quotient bit per cell.
   // ------------------------------------------------------------------------
   logic [AW-1:0]   dv_rem [NW+1];
   logic [NW-1:0]   dv_nq  [NW+1];
   logic [AW-1:0]   dv_den [NW+1];
   logic [DVTW-1:0] dv_tag [NW+1];

   assign dv_v[0]   = vp3_ff;
   assign dv_tag[0] = dtag3_ff;
   assign dv_rem[0] = '0;
   assign dv_nq[0]  = nq3_ff;
   assign dv_den[0] = den3_ff;

   for (genvar g = 0; g < NW; g++) begin : g_div
      lci_div_cell #(.NW(NW), .AW(AW), .TW(DVTW)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .valid_i (dv_v[g]),
         .tag_i   (dv_tag[g]),
         .rem_i   (dv_rem[g]),
         .nq_i    (dv_nq[g]),
         .den_i   (dv_den[g]),
         .valid_o (dv_v[g+1]),
         .tag_o   (dv_tag[g+1]),
         .rem_o   (dv_rem[g+1]),
         .nq_o    (dv_nq[g+1]),
         .den_o   (dv_den[g+1])
      );
   end

   // ------------------------------------------------------------------------
   // Saturate and sign the path parameter, then form the hit point.
   // ------------------------------------------------------------------------
   dv_tag_type            dv_end;
   logic [C-1:0]          lim;
   dv_tag_type            tt1_ff, tt2_ff, th1_ff, th2_ff;
   logic [C-1:0]          qm1_ff;
   logic signed [C-1:0]   t2_ff, th1_t_ff, th2_t_ff;
   logic signed [XW-1:0]  px1_ff, py1_ff, pz1_ff;
   logic signed [HW-1:0]  sx2_ff, sy2_ff, sz2_ff;

   always_comb begin
      dv_end = dv_tag[NW];
      lim    = dv_end.neg ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tt1_ff <= dv_end;
         qm1_ff <= (dv_nq[NW] > NW'(lim)) ? lim : dv_nq[NW][C-1:0];

         tt2_ff <= tt1_ff;
         t2_ff  <= tt1_ff.neg ? C'(-qm1_ff) : C'(qm1_ff);

         th1_ff   <= tt2_ff;
         th1_t_ff <= t2_ff;
         px1_ff   <= $signed(tt2_ff.trk.dx) * t2_ff;
         py1_ff   <= $signed(tt2_ff.trk.dy) * t2_ff;
         pz1_ff   <= $signed(tt2_ff.trk.dz) * t2_ff;

         th2_ff   <= th1_ff;
         th2_t_ff <= th1_t_ff;
         sx2_ff   <= HW'($signed(th1_ff.trk.x0)) + HW'(px1_ff >>> F);
         sy2_ff   <= HW'($signed(th1_ff.trk.y0)) + HW'(py1_ff >>> F);
         sz2_ff   <= HW'($signed(th1_ff.trk.z0)) + HW'(pz1_ff >>> F);
      end
   end

   // Final result; a miss reports zeros with only the no-hit flag raised.
   res_type fin;

   always_comb begin
      if (th2_ff.nohit) begin
         fin        = '0;
         fin.no_hit = 1'b1;
      end else begin
         fin.path   = th2_t_ff;
         fin.hx     = sat_c(sx2_ff);
         fin.hy     = sat_c(sy2_ff);
         fin.hz     = sat_c(sz2_ff);
         fin.no_hit = 1'b0;
         fin.behind = th2_ff.behind;
      end
   end

   // ------------------------------------------------------------------------
   // Output register with a one-item skid entry behind it.
   // ------------------------------------------------------------------------
   logic    rsp_valid_ff;
   res_type out_ff, skid_ff;
   logic    out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (out_free) begin
            out_ff       <= skid_ff;
            rsp_valid_ff <= 1'b1;
            skid_full_ff <= 1'b0;
         end
      end else if (vh2_ff) begin
         if (out_free) begin
            out_ff       <= fin;
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_ff      <= fin;
            skid_full_ff <= 1'b1;
         end
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_path_param   = out_ff.path;
   assign rsp_hit_x        = out_ff.hx;
   assign rsp_hit_y        = out_ff.hy;
   assign rsp_hit_z        = out_ff.hz;
   assign rsp_no_hit       = out_ff.no_hit;
   assign rsp_behind_start = out_ff.behind;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------

   // The skid entry only fills behind a result that is being held.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> rsp_valid_ff)
      else $error("skid entry full with no result in the output register");

   // A held skid item drains as soon as the output side takes.
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_full_ff && !rsp_stall) |=> !skid_full_ff)
      else $error("skid entry did not drain");

   // An accepted item enters the first stage.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v0_ff)
      else $error("accepted item lost at the input stage");

   // A hit behind the start always has a path parameter at or below zero.
   a_behind_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_behind_start) |-> (rsp_path_param[C-1] || rsp_path_param == '0))
      else $error("behind-start result with positive path parameter");

   // A miss carries zero payload.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_hit) |-> (rsp_path_param == '0 && !rsp_behind_start))
      else $error("no-hit result with nonzero payload");

endmodule
